// File: hdl/aoc_pkg.sv
// Shared types, constants and mode codes for the alpha-over compositor.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package aoc_pkg;

    // channel full scale
    localparam int unsigned FULL      = 255;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned NUM_CH    = 3;
    // blend numerator, denominator and pre-shifted divisor widths
    localparam int unsigned NUM_W     = 25;
    localparam int unsigned DEN_W     = 16;
    localparam int unsigned QBITS     = 8;
    localparam int unsigned DSH_W     = DEN_W + QBITS - 1;

    localparam logic [CH_W-1:0] CH_MAX = CH_W'(FULL);

    // how a pixel pair is handled
    localparam logic [1:0] MODE_OPAQUE = 2'd0;  // top opaque or bottom clear
    localparam logic [1:0] MODE_CLEAR  = 2'd1;  // top fully transparent
    localparam logic [1:0] MODE_BLEND  = 2'd2;  // general over blend

    typedef struct packed {
        logic [7:0] top_red;
        logic [7:0] top_green;
        logic [7:0] top_blue;
        logic [7:0] top_alpha;
        logic [7:0] bottom_red;
        logic [7:0] bottom_green;
        logic [7:0] bottom_blue;
        logic [7:0] bottom_alpha;
        logic       write_down;
    } t_in_word;

    typedef struct packed {
        logic [7:0] new_top_red;
        logic [7:0] new_top_green;
        logic [7:0] new_top_blue;
        logic [7:0] new_top_alpha;
        logic [7:0] new_bottom_red;
        logic [7:0] new_bottom_green;
        logic [7:0] new_bottom_blue;
        logic [7:0] new_bottom_alpha;
    } t_out_word;

    // state of one pixel pair inside the divider pipeline
    typedef struct packed {
        t_in_word                         pix;
        logic [1:0]                       mode;
        logic [CH_W-1:0]                  alpha;
        logic [NUM_CH-1:0]                sat;
        logic [NUM_CH-1:0][NUM_W-1:0]     rem;
        logic [NUM_CH-1:0][QBITS-1:0]     quo;
        logic [DSH_W-1:0]                 dsh;
    } t_work;

endpackage

`default_nettype wire

// File: hdl/aoc_front.sv
// Front end: mode decode, products, result alpha, numerators and divisor.
// Four register stages with stall chaining; uses aoc_pkg.
`default_nettype none

module aoc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  aoc_pkg::t_in_word    i_word,
    output logic                 o_stall,
    output logic                 o_valid,
    output aoc_pkg::t_work       o_work,
    input  wire                  i_stall
);

    // stage 1: mode, 255-ta, ba*(255-ta), tc*ta
    logic                                         r_v1;
    aoc_pkg::t_in_word                            r_pix1;
    logic [1:0]                                   r_mode1, n_mode1;
    logic [15:0]                                  r_pba1;
    logic [aoc_pkg::NUM_CH-1:0][15:0]             r_tcta1, n_tcta1;
    logic [7:0]                                   n_inv1;

    // stage 2: alpha, tc*ta*255, bc*ba*(255-ta)
    logic                                         r_v2;
    aoc_pkg::t_in_word                            r_pix2;
    logic [1:0]                                   r_mode2;
    logic [7:0]                                   r_alpha2, n_alpha2;
    logic [aoc_pkg::NUM_CH-1:0][23:0]             r_n12, n_n12;
    logic [aoc_pkg::NUM_CH-1:0][23:0]             r_m2, n_m2;
    logic [15:0]                                  n_q255;
    logic [8:0]                                   n_asum;

    // stage 3: numerator sums and divisor
    logic                                         r_v3;
    aoc_pkg::t_in_word                            r_pix3;
    logic [1:0]                                   r_mode3;
    logic [7:0]                                   r_alpha3;
    logic [aoc_pkg::NUM_CH-1:0][aoc_pkg::NUM_W-1:0] r_num3, n_num3;
    logic [aoc_pkg::DEN_W-1:0]                    r_den3, n_den3;

    // stage 4: saturation check, divisor pre-shift
    logic                                         r_v4;
    aoc_pkg::t_work                               r_w4, n_w4;

    logic rdy1, rdy2, rdy3, rdy4;
    logic [7:0] tc [aoc_pkg::NUM_CH];
    logic [7:0] bc2 [aoc_pkg::NUM_CH];

    assign rdy4    = !r_v4 || !i_stall;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign o_valid = r_v4;
    assign o_work  = r_w4;

    assign tc[0]  = i_word.top_red;
    assign tc[1]  = i_word.top_green;
    assign tc[2]  = i_word.top_blue;
    assign bc2[0] = r_pix1.bottom_red;
    assign bc2[1] = r_pix1.bottom_green;
    assign bc2[2] = r_pix1.bottom_blue;

    // stage 1 logic
    always_comb begin
        n_inv1 = aoc_pkg::CH_MAX - i_word.top_alpha;
        if (i_word.top_alpha == aoc_pkg::CH_MAX || i_word.bottom_alpha == 8'd0) begin
            n_mode1 = aoc_pkg::MODE_OPAQUE;
        end else if (i_word.top_alpha == 8'd0) begin
            n_mode1 = aoc_pkg::MODE_CLEAR;
        end else begin
            n_mode1 = aoc_pkg::MODE_BLEND;
        end
        for (int c = 0; c < aoc_pkg::NUM_CH; c++) begin
            n_tcta1[c] = 16'(tc[c] * i_word.top_alpha);
        end
    end

    // stage 2 logic: floor(p/255) = (p + 1 + (p >> 8)) >> 8 for 16-bit p
    always_comb begin
        n_q255   = r_pba1 + 16'd1 + {8'd0, r_pba1[15:8]};
        n_asum   = {1'b0, r_pix1.top_alpha} + {1'b0, n_q255[15:8]};
        n_alpha2 = n_asum[8] ? aoc_pkg::CH_MAX : n_asum[7:0];
        for (int c = 0; c < aoc_pkg::NUM_CH; c++) begin
            n_n12[c] = {r_tcta1[c], 8'd0} - {8'd0, r_tcta1[c]};
            n_m2[c]  = 24'(bc2[c] * r_pba1);
        end
    end

    // stage 3 logic
    always_comb begin
        n_den3 = {r_alpha2, 8'd0} - {8'd0, r_alpha2};
        for (int c = 0; c < aoc_pkg::NUM_CH; c++) begin
            n_num3[c] = {1'b0, r_n12[c]} + {1'b0, r_m2[c]};
        end
    end

    // stage 4 logic: quotient of 256 or more saturates
    always_comb begin
        n_w4.pix   = r_pix3;
        n_w4.mode  = r_mode3;
        n_w4.alpha = r_alpha3;
        n_w4.rem   = r_num3;
        n_w4.quo   = '0;
        n_w4.dsh   = {r_den3, {(aoc_pkg::QBITS-1){1'b0}}};
        for (int c = 0; c < aoc_pkg::NUM_CH; c++) begin
            n_w4.sat[c] = r_num3[c] >= aoc_pkg::NUM_W'({r_den3, 8'd0});
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_pix1  <= i_word;
            r_mode1 <= n_mode1;
            r_pba1  <= 16'(i_word.bottom_alpha * n_inv1);
            r_tcta1 <= n_tcta1;
        end
        if (rdy2 && r_v1) begin
            r_pix2   <= r_pix1;
            r_mode2  <= r_mode1;
            r_alpha2 <= n_alpha2;
            r_n12    <= n_n12;
            r_m2     <= n_m2;
        end
        if (rdy3 && r_v2) begin
            r_pix3   <= r_pix2;
            r_mode3  <= r_mode2;
            r_alpha3 <= r_alpha2;
            r_num3   <= n_num3;
            r_den3   <= n_den3;
        end
        if (rdy4 && r_v3) begin
            r_w4 <= n_w4;
        end
    end

endmodule

`default_nettype wire

// File: hdl/aoc_div_stage.sv
// One divider stage: two restoring quotient bits for each color channel.
// Single register stage with stall chaining; uses aoc_pkg.
`default_nettype none

module aoc_div_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  aoc_pkg::t_work   i_work,
    output logic             o_stall,
    output logic             o_valid,
    output aoc_pkg::t_work   o_work,
    input  wire              i_stall
);

    logic           r_v;
    aoc_pkg::t_work r_w, n_w;
    logic           rdy;

    assign rdy     = !r_v || !i_stall;
    assign o_stall = !rdy;
    assign o_valid = r_v;
    assign o_work  = r_w;

    // two compare-subtract steps, divisor halves after each
    always_comb begin
        logic [aoc_pkg::DSH_W-1:0] d;
        n_w = i_work;
        d   = i_work.dsh;
        for (int s = 0; s < 2; s++) begin
            for (int c = 0; c < aoc_pkg::NUM_CH; c++) begin
                if (n_w.rem[c] >= aoc_pkg::NUM_W'(d)) begin
                    n_w.rem[c] = n_w.rem[c] - aoc_pkg::NUM_W'(d);
                    n_w.quo[c] = {n_w.quo[c][aoc_pkg::QBITS-2:0], 1'b1};
                end else begin
                    n_w.quo[c] = {n_w.quo[c][aoc_pkg::QBITS-2:0], 1'b0};
                end
            end
            d = d >> 1;
        end
        n_w.dsh = d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_w <= n_w;
        end
    end

endmodule

`default_nettype wire

// File: hdl/aoc_pack.sv
// Output stage: picks blend, copy or pass-through and registers the result word.
// Single register stage facing the output channel; uses aoc_pkg.
`default_nettype none

module aoc_pack (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  aoc_pkg::t_work      i_work,
    output logic                o_stall,
    output logic                o_valid,
    output aoc_pkg::t_out_word  o_word,
    input  wire                 i_stall
);

    logic                 r_v;
    aoc_pkg::t_out_word   r_word, n_word;
    logic                 rdy;
    logic [31:0]          top_px, bot_px, res_px;
    logic [7:0]           ch [aoc_pkg::NUM_CH];

    assign rdy     = !r_v || !i_stall;
    assign o_stall = !rdy;
    assign o_valid = r_v;
    assign o_word  = r_word;

    // saturated channels and the blended pixel
    always_comb begin
        for (int c = 0; c < aoc_pkg::NUM_CH; c++) begin
            ch[c] = i_work.sat[c] ? aoc_pkg::CH_MAX : i_work.quo[c];
        end
    end

    assign top_px = {i_work.pix.top_red, i_work.pix.top_green,
                     i_work.pix.top_blue, i_work.pix.top_alpha};
    assign bot_px = {i_work.pix.bottom_red, i_work.pix.bottom_green,
                     i_work.pix.bottom_blue, i_work.pix.bottom_alpha};
    assign res_px = {ch[0], ch[1], ch[2], i_work.alpha};

    // result selection
    always_comb begin
        logic [31:0] nt, nb;
        nt = top_px;
        nb = bot_px;
        unique case (i_work.mode)
            aoc_pkg::MODE_OPAQUE: begin
                if (i_work.pix.write_down && i_work.pix.top_alpha != 8'd0) nb = top_px;
            end
            aoc_pkg::MODE_CLEAR: begin
                if (!i_work.pix.write_down && i_work.pix.bottom_alpha != 8'd0) nt = bot_px;
            end
            aoc_pkg::MODE_BLEND: begin
                if (i_work.pix.write_down) begin
                    nb = res_px;
                end else begin
                    nt = res_px;
                end
            end
            default: begin
                nt = top_px;
                nb = bot_px;
            end
        endcase
        n_word = {nt, nb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

// File: hdl/alpha_over_compositor.sv
// Porter-Duff "over" compositor for a pair of non-premultiplied RGBA8 pixels.
// Takes one pixel-pair word per clock and returns one result word per clock
// while nothing stalls; each word passes through the nine register stages
// in order. The stages are four front stages (products, result alpha,
// numerators, divisor and saturation check), four restoring divider stages
// of two quotient bits each, and the output register. Each stage holds its
// word under a stall and empty stages fill up, so o_in_stall rises only once
// every stage is full and the output is held. Stateless: no configuration,
// no clearing after reset.
// Depends on aoc_pkg, aoc_front, aoc_div_stage and aoc_pack.
`default_nettype none

module alpha_over_compositor (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  aoc_pkg::t_in_word   i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output aoc_pkg::t_out_word  o_out_word,
    input  wire                 i_out_stall
);

    localparam int unsigned DIV_STAGES = aoc_pkg::QBITS / 2;

    aoc_pkg::t_work w [DIV_STAGES+1];
    logic           v [DIV_STAGES+1];
    logic           s [DIV_STAGES+1];

    // front end
    aoc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_stall (o_in_stall),
        .o_valid (v[0]),
        .o_work  (w[0]),
        .i_stall (s[0])
    );

    // divider pipeline
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        aoc_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .i_work  (w[k]),
            .o_stall (s[k]),
            .o_valid (v[k+1]),
            .o_work  (w[k+1]),
            .i_stall (s[k+1])
        );
    end

    // output register
    aoc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[DIV_STAGES]),
        .i_work  (w[DIV_STAGES]),
        .o_stall (s[DIV_STAGES]),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// File: hdl/aoc_checker.sv
// Port-level checks for the compositor, attached to the top level by bind.
// Depends on aoc_pkg and alpha_over_compositor.
`default_nettype none

module aoc_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_in_stall,
    input wire                 o_out_valid,
    input aoc_pkg::t_out_word  o_out_word,
    input wire                 i_out_stall
);

    // a held output word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // a held output word does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // input side backs up only when the output is full and stalled
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind alpha_over_compositor aoc_checker u_aoc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
